FILE: src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, register indexes and stage payload types for the barometric
// pressure and temperature compensation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  // field widths
  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int IDX_W   = 3;
  localparam int DT_W    = 25;
  localparam int TEMP_W  = 21;
  localparam int T2_W    = 18;
  localparam int OFF_W   = 42;
  localparam int SENS_W  = 42;
  localparam int SQ_W    = 36;
  localparam int OUT_W   = 32;

  // temperature breakpoints in 0.01 degC
  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 21'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -21'sd1500;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_C1          = 3'd0;
  localparam logic [IDX_W-1:0] REG_C2          = 3'd1;
  localparam logic [IDX_W-1:0] REG_C3          = 3'd2;
  localparam logic [IDX_W-1:0] REG_C4          = 3'd3;
  localparam logic [IDX_W-1:0] REG_C5          = 3'd4;
  localparam logic [IDX_W-1:0] REG_C6          = 3'd5;
  localparam logic [IDX_W-1:0] REG_CALIB_VALID = 3'd6;

  // first-order terms leaving stage 3
  typedef struct packed {
    logic                     ok;
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic [T2_W-1:0]          t2;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } first_t;

  // corrected terms leaving stage 5
  typedef struct packed {
    logic                     ok;
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } second_t;

endpackage

`default_nettype wire

FILE: src/baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Second-order compensation of raw barometer conversions, seven-stage pipe.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel: sample_valid/sample_stall carry one item, a raw pressure
//   conversion d1_raw and a raw temperature conversion d2_raw.
//   Result channel: result_valid/result_stall carry ok, pressure_centi_mbar
//   and temp_centi_degc for each item, in order.
//   Config port: cfg_we writes cfg_data into register cfg_index (C1..C6,
//   then calib_valid); write only while no item is in flight.
//   Path: a taken item passes stages 1 to 7 in order and shows on
//   result_valid once it sits in stage 7, the output register.
//   Throughput: one item per cycle while the result side does not stall; each of the seven stages holds one item.
//   Stall: a stalled result holds in the output register. Earlier stages
//   keep moving into empty slots, so the sample side stalls only once all
//   seven stages are full.
//   Reset: rst clears all stage valid bits and the config registers. With
//   calib_valid clear, results carry ok = 0 and zero values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module baro_pressure_temp_compensation (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [bpc_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [bpc_pkg::COEF_W-1:0]      cfg_data,
  input  wire logic                            sample_valid,
  output logic                                 sample_stall,
  input  wire logic [bpc_pkg::RAW_W-1:0]       d1_raw,
  input  wire logic [bpc_pkg::RAW_W-1:0]       d2_raw,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic                                 ok,
  output logic signed [bpc_pkg::OUT_W-1:0]     pressure_centi_mbar,
  output logic signed [bpc_pkg::OUT_W-1:0]     temp_centi_degc
);

  // configuration registers
  logic [bpc_pkg::COEF_W-1:0]  coef_c1;
  logic [bpc_pkg::COEF_W-1:0]  coef_c2;
  logic [bpc_pkg::COEF_W-1:0]  coef_c3;
  logic [bpc_pkg::COEF_W-1:0]  coef_c4;
  logic [bpc_pkg::COEF_W-1:0]  coef_c5;
  logic [bpc_pkg::COEF_W-1:0]  coef_c6;
  logic                        calib_valid;

  // pipeline control
  logic [7:1]                  vld;
  logic [7:1]                  en;

  // stage payloads
  bpc_pkg::first_t             first;
  bpc_pkg::second_t            second;
  logic [bpc_pkg::OUT_W-1:0]   pressure_raw;
  logic [bpc_pkg::OUT_W-1:0]   temp_raw;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_c1     <= '0;
      coef_c2     <= '0;
      coef_c3     <= '0;
      coef_c4     <= '0;
      coef_c5     <= '0;
      coef_c6     <= '0;
      calib_valid <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::REG_C1:          coef_c1     <= cfg_data;
        bpc_pkg::REG_C2:          coef_c2     <= cfg_data;
        bpc_pkg::REG_C3:          coef_c3     <= cfg_data;
        bpc_pkg::REG_C4:          coef_c4     <= cfg_data;
        bpc_pkg::REG_C5:          coef_c5     <= cfg_data;
        bpc_pkg::REG_C6:          coef_c6     <= cfg_data;
        bpc_pkg::REG_CALIB_VALID: calib_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the next one moves
  always_comb begin
    en[7] = !vld[7] || !result_stall;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= sample_valid;
      end
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign sample_stall = !en[1];
  assign result_valid = vld[7];

  bpc_first_order u_first (
    .clk      (clk),
    .en       (en[3:1]),
    .calib_ok (calib_valid),
    .d1_raw   (d1_raw),
    .d2_raw   (d2_raw),
    .coef_c1  (coef_c1),
    .coef_c2  (coef_c2),
    .coef_c3  (coef_c3),
    .coef_c4  (coef_c4),
    .coef_c5  (coef_c5),
    .coef_c6  (coef_c6),
    .first    (first)
  );

  bpc_second_order u_second (
    .clk    (clk),
    .en     (en[5:4]),
    .first  (first),
    .second (second)
  );

  bpc_pressure u_pressure (
    .clk                 (clk),
    .en                  (en[7:6]),
    .second              (second),
    .ok                  (ok),
    .pressure_centi_mbar (pressure_raw),
    .temp_centi_degc     (temp_raw)
  );

  assign pressure_centi_mbar = $signed(pressure_raw);
  assign temp_centi_degc     = $signed(temp_raw);

  // an accepted item lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> vld[1])
    else $error("accepted item did not enter stage 1");

  // the sample side stalls only with every stage full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (&vld))
    else $error("sample stalled while a stage was empty");

  // uncalibrated results read as zero
  a_zero_uncal: assert property (@(posedge clk) disable iff (rst)
    result_valid && !ok |-> pressure_centi_mbar == '0 && temp_centi_degc == '0)
    else $error("nonzero result without calibration");

  // compensated temperature stays within its 21-bit range
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && ok |->
      temp_centi_degc[31:20] == 12'h000 || temp_centi_degc[31:20] == 12'hfff)
    else $error("temperature out of range");

endmodule

`default_nettype wire

FILE: src/bpc_first_order.sv
// ----------------------------------------------------------------------------
// bpc_first_order
// Stages 1 to 3: dT, the four products on dT, then TEMP, OFF, SENS and T2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpc_first_order (
  input  wire logic                          clk,
  input  wire logic [2:0]                    en,
  input  wire logic                          calib_ok,
  input  wire logic [bpc_pkg::RAW_W-1:0]     d1_raw,
  input  wire logic [bpc_pkg::RAW_W-1:0]     d2_raw,
  input  wire logic [bpc_pkg::COEF_W-1:0]    coef_c1,
  input  wire logic [bpc_pkg::COEF_W-1:0]    coef_c2,
  input  wire logic [bpc_pkg::COEF_W-1:0]    coef_c3,
  input  wire logic [bpc_pkg::COEF_W-1:0]    coef_c4,
  input  wire logic [bpc_pkg::COEF_W-1:0]    coef_c5,
  input  wire logic [bpc_pkg::COEF_W-1:0]    coef_c6,
  output bpc_pkg::first_t                    first
);

  // stage 1 registers
  logic                      ok1;
  logic [23:0]               d1_1;
  logic signed [24:0]        dt1;
  logic signed [24:0]        dt_next;

  // stage 2 registers
  logic                      ok2;
  logic [23:0]               d1_2;
  logic signed [41:0]        p6;
  logic signed [41:0]        p4;
  logic signed [41:0]        p3;
  logic signed [49:0]        dtsq;
  logic signed [41:0]        p6_next;
  logic signed [41:0]        p4_next;
  logic signed [41:0]        p3_next;
  logic signed [49:0]        dtsq_next;

  // stage 3 combinational terms
  logic signed [41:0]        p6_sh;
  logic signed [20:0]        temp_next;
  logic signed [41:0]        off_next;
  logic signed [41:0]        sens_next;

  // subtract the reference temperature word
  assign dt_next = $signed({1'b0, d2_raw}) - $signed({1'b0, coef_c5, 8'd0});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok1  <= calib_ok;
      d1_1 <= d1_raw;
      dt1  <= dt_next;
    end
  end

  // form the products on dT, one multiplier each
  assign p6_next   = dt1 * $signed({1'b0, coef_c6});
  assign p4_next   = dt1 * $signed({1'b0, coef_c4});
  assign p3_next   = dt1 * $signed({1'b0, coef_c3});
  assign dtsq_next = dt1 * dt1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ok2  <= ok1;
      d1_2 <= d1_1;
      p6   <= p6_next;
      p4   <= p4_next;
      p3   <= p3_next;
      dtsq <= dtsq_next;
    end
  end

  // scale and add the base terms
  assign p6_sh     = p6 >>> 23;
  assign temp_next = $signed(p6_sh[20:0]) + bpc_pkg::TEMP_REF;
  assign off_next  = $signed({10'd0, coef_c2, 16'd0}) + (p4 >>> 7);
  assign sens_next = $signed({11'd0, coef_c1, 15'd0}) + (p3 >>> 8);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      first.ok   <= ok2;
      first.d1   <= d1_2;
      first.temp <= temp_next;
      // dT squared is never negative: the shift is a plain slice
      first.t2   <= dtsq[48:31];
      first.off  <= off_next;
      first.sens <= sens_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/bpc_second_order.sv
// ----------------------------------------------------------------------------
// bpc_second_order
// Stages 4 and 5: low-temperature correction of TEMP, OFF and SENS.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpc_second_order (
  input  wire logic             clk,
  input  wire logic [1:0]       en,
  input  wire bpc_pkg::first_t  first,
  output bpc_pkg::second_t      second
);

  // stage 4 combinational terms
  logic signed [20:0]  temp_in;
  logic signed [20:0]  dd;
  logic signed [20:0]  ee;
  logic signed [41:0]  dsq_next;
  logic signed [41:0]  esq_next;
  logic                warm_low;
  logic                cold_low;
  logic signed [20:0]  temp_next;

  // stage 4 registers
  logic                ok4;
  logic [23:0]         d1_4;
  logic signed [20:0]  temp4;
  logic signed [41:0]  off4;
  logic signed [41:0]  sens4;
  logic [35:0]         dsq4;
  logic [35:0]         esq4;
  logic                below_ref4;
  logic                below_cold4;

  // stage 5 combinational terms
  logic [41:0]         d5;
  logic [41:0]         e7;
  logic [41:0]         e11;
  logic [41:0]         off2;
  logic [41:0]         sens2;

  // distances from both breakpoints and their squares
  assign temp_in   = first.temp;
  assign dd        = temp_in - bpc_pkg::TEMP_REF;
  assign ee        = temp_in - bpc_pkg::TEMP_COLD;
  assign dsq_next  = dd * dd;
  assign esq_next  = ee * ee;
  assign warm_low  = temp_in < bpc_pkg::TEMP_REF;
  assign cold_low  = temp_in < bpc_pkg::TEMP_COLD;
  assign temp_next = warm_low ? (temp_in - $signed({3'd0, first.t2})) : temp_in;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok4         <= first.ok;
      d1_4        <= first.d1;
      temp4       <= temp_next;
      off4        <= first.off;
      sens4       <= first.sens;
      dsq4        <= dsq_next[35:0];
      esq4        <= esq_next[35:0];
      below_ref4  <= warm_low;
      below_cold4 <= cold_low;
    end
  end

  // scale the squares by shift and add or subtract
  assign d5  = {6'd0, dsq4} + {4'd0, dsq4, 2'd0};
  assign e7  = {3'd0, esq4, 3'd0} - {6'd0, esq4};
  assign e11 = {3'd0, esq4, 3'd0} + {5'd0, esq4, 1'd0} + {6'd0, esq4};

  always_comb begin
    off2  = '0;
    sens2 = '0;
    if (below_ref4) begin
      off2  = d5 >> 1;
      sens2 = d5 >> 2;
      if (below_cold4) begin
        off2  = off2 + e7;
        sens2 = sens2 + (e11 >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      second.ok   <= ok4;
      second.d1   <= d1_4;
      second.temp <= temp4;
      second.off  <= off4 - $signed(off2);
      second.sens <= sens4 - $signed(sens2);
    end
  end

endmodule

`default_nettype wire

FILE: src/bpc_pressure.sv
// ----------------------------------------------------------------------------
// bpc_pressure
// Stages 6 and 7: D1 times SENS as two partial products, then the offset,
// the final scaling and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpc_pressure (
  input  wire logic                       clk,
  input  wire logic [1:0]                 en,
  input  wire bpc_pkg::second_t           second,
  output logic                            ok,
  output logic [bpc_pkg::OUT_W-1:0]       pressure_centi_mbar,
  output logic [bpc_pkg::OUT_W-1:0]       temp_centi_degc
);

  // stage 6 combinational terms
  logic [44:0]         lo_next;
  logic signed [45:0]  hi_next;
  logic signed [41:0]  sens_in;

  // stage 6 registers
  logic                ok6;
  logic signed [20:0]  temp6;
  logic signed [41:0]  off6;
  logic [44:0]         lo6;
  logic signed [45:0]  hi6;

  // stage 7 combinational terms
  logic signed [47:0]  q;

  // split SENS at bit 21: the shift by 21 then needs no wide add
  assign sens_in = second.sens;
  assign lo_next = second.d1 * sens_in[20:0];
  assign hi_next = $signed({1'b0, second.d1}) * $signed(sens_in[41:21]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok6   <= second.ok;
      temp6 <= second.temp;
      off6  <= second.off;
      lo6   <= lo_next;
      hi6   <= hi_next;
    end
  end

  // floor(D1*SENS / 2^21) - OFF
  assign q = hi6 + $signed({1'b0, lo6[44:21]}) - off6;

  // hold results at zero while calibration is not trusted
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ok <= ok6;
      if (ok6) begin
        pressure_centi_mbar <= q[46:15];
        temp_centi_degc     <= {{11{temp6[20]}}, temp6};
      end else begin
        pressure_centi_mbar <= '0;
        temp_centi_degc     <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/compensation_checker.sv
// ----------------------------------------------------------------------------
// compensation_checker
// Watches the configuration port and both item channels of the barometer
// compensation block. It keeps its own copy of the calibration words and
// predicts each reading from them. Each result that leaves the block is
// compared with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module compensation_checker
  import bpc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [COEF_W-1:0]       cfg_data,
  input  logic                    sample_valid,
  input  logic                    sample_stall,
  input  logic [RAW_W-1:0]        d1_raw,
  input  logic [RAW_W-1:0]        d2_raw,
  input  logic                    result_valid,
  input  logic                    result_stall,
  input  logic                    ok,
  input  logic signed [OUT_W-1:0] pressure_centi_mbar,
  input  logic signed [OUT_W-1:0] temp_centi_degc,
  output int                      fail_count,
  output int                      outstanding,
  output int                      checked
);

  // breakpoints of the second-order correction, 0.01 degC
  localparam longint WARM_LIMIT = 2000;
  localparam longint COLD_LIMIT = -1500;
  localparam int     MAX_REPORTS = 20;

  typedef struct packed {
    logic                    ok;
    logic signed [OUT_W-1:0] pressure;
    logic signed [OUT_W-1:0] temp;
  } reading_t;

  logic [COEF_W-1:0] cal_c1, cal_c2, cal_c3, cal_c4, cal_c5, cal_c6;
  logic              cal_valid;
  reading_t          expected_readings[$];
  reading_t          want;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    checked     = 0;
  end

  // compensate one raw pair with the current calibration words
  function automatic reading_t compensate(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
    reading_t r;
    longint   dt, temp, off, sens, t2, off2, sens2, press, warm_gap, cold_gap;
    r = '0;
    if (!cal_valid) return r;
    dt   = longint'(d2) - (longint'(cal_c5) << 8);
    temp = WARM_LIMIT + ((dt * longint'(cal_c6)) >>> 23);
    off  = (longint'(cal_c2) << 16) + ((longint'(cal_c4) * dt) >>> 7);
    sens = (longint'(cal_c1) << 15) + ((longint'(cal_c3) * dt) >>> 8);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    // low temperature correction, stronger below the cold limit
    if (temp < WARM_LIMIT) begin
      warm_gap = temp - WARM_LIMIT;
      t2    = (dt * dt) >>> 31;
      off2  = (5 * warm_gap * warm_gap) >>> 1;
      sens2 = (5 * warm_gap * warm_gap) >>> 2;
      if (temp < COLD_LIMIT) begin
        cold_gap = temp - COLD_LIMIT;
        off2  += 7 * cold_gap * cold_gap;
        sens2 += (11 * cold_gap * cold_gap) >>> 1;
      end
    end
    temp -= t2;
    off  -= off2;
    sens -= sens2;
    press = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
    r.ok       = 1'b1;
    r.pressure = press[OUT_W-1:0];
    r.temp     = temp[OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_val);
    if (fail_count < MAX_REPORTS)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
    fail_count++;
  endtask

  // track register writes
  always @(posedge clk) begin
    if (rst) begin
      {cal_c1, cal_c2, cal_c3, cal_c4, cal_c5, cal_c6} <= '0;
      cal_valid <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_C1:          cal_c1 <= cfg_data;
        REG_C2:          cal_c2 <= cfg_data;
        REG_C3:          cal_c3 <= cfg_data;
        REG_C4:          cal_c4 <= cfg_data;
        REG_C5:          cal_c5 <= cfg_data;
        REG_C6:          cal_c6 <= cfg_data;
        REG_CALIB_VALID: cal_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // compare results first, then queue the prediction for a new item
  always @(posedge clk) begin
    if (rst) begin
      expected_readings.delete();
      outstanding <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result with nothing expected", pressure_centi_mbar, 0);
        end else begin
          want = expected_readings.pop_front();
          checked++;
          if (ok !== want.ok)
            report_mismatch("ok", ok, want.ok);
          if (pressure_centi_mbar !== want.pressure)
            report_mismatch("pressure_centi_mbar", pressure_centi_mbar, want.pressure);
          if (temp_centi_degc !== want.temp)
            report_mismatch("temp_centi_degc", temp_centi_degc, want.temp);
        end
      end
      if (sample_valid && !sample_stall)
        expected_readings.push_back(compensate(d1_raw, d2_raw));
      outstanding <= expected_readings.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the barometer compensation block with raw pressure and temperature
// pairs under many calibration settings. It starts with directed pairs at the
// field extremes and at the temperature breakpoints. Random pairs then
// follow, spread around the reference temperature. Both channels idle at
// random, with one long result hold. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bpc_pkg::*;

  localparam int             PHASES      = 10;
  localparam int             PHASE_ITEMS = 55;
  localparam int             LONG_HOLD   = 200;
  localparam int             IDLE_LIMIT  = 4000;
  localparam int             SETTLE      = 20;
  localparam int             RAW_MAX     = 16777215;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  // typical factory calibration
  localparam logic [COEF_W-1:0] TYP_C1 = 16'd40127;
  localparam logic [COEF_W-1:0] TYP_C2 = 16'd36924;
  localparam logic [COEF_W-1:0] TYP_C3 = 16'd23317;
  localparam logic [COEF_W-1:0] TYP_C4 = 16'd23282;
  localparam logic [COEF_W-1:0] TYP_C5 = 16'd33464;
  localparam logic [COEF_W-1:0] TYP_C6 = 16'd28312;

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    cfg_we       = 1'b0;
  logic [IDX_W-1:0]        cfg_index    = '0;
  logic [COEF_W-1:0]       cfg_data     = '0;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  logic [RAW_W-1:0]        d1_raw       = '0;
  logic [RAW_W-1:0]        d2_raw       = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic                    ok;
  logic signed [OUT_W-1:0] pressure_centi_mbar;
  logic signed [OUT_W-1:0] temp_centi_degc;

  int fail_count, outstanding, checked;
  int items_sent    = 0;
  int cal_loads     = 0;
  int input_blocked = 0;
  int idle_cycles   = 0;
  int send_idle_pct = 30;
  int recv_idle_pct = 30;
  int hold_requests = 0;
  int holds_done    = 0;
  int stall_left    = 0;
  logic [COEF_W-1:0] cur_c5 = '0;

  always #5 clk = ~clk;

  baro_pressure_temp_compensation DUT (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .sample_valid        (sample_valid),
    .sample_stall        (sample_stall),
    .d1_raw              (d1_raw),
    .d2_raw              (d2_raw),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .ok                  (ok),
    .pressure_centi_mbar (pressure_centi_mbar),
    .temp_centi_degc     (temp_centi_degc)
  );

  compensation_checker u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .sample_valid        (sample_valid),
    .sample_stall        (sample_stall),
    .d1_raw              (d1_raw),
    .d2_raw              (d2_raw),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .ok                  (ok),
    .pressure_centi_mbar (pressure_centi_mbar),
    .temp_centi_degc     (temp_centi_degc),
    .fail_count          (fail_count),
    .outstanding         (outstanding),
    .checked             (checked)
  );

  // mostly short gaps, now and then a long one
  function automatic int rand_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // stall the result side; a requested long hold is counted here
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (hold_requests != holds_done) begin
      holds_done = hold_requests;
      stall_left = LONG_HOLD - 1;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      stall_left = rand_gap() - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // end the run when no handshake or write happens for too long
  always @(posedge clk) begin
    if (sample_valid && sample_stall) input_blocked++;
    if (rst || cfg_we || (sample_valid && !sample_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("FAIL baro_pressure_temp_compensation");
      $finish;
    end
  end

  task automatic send_item(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = rand_gap();
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    d1_raw       <= d1;
    d2_raw       <= d2;
    do @(posedge clk); while (sample_stall);
    items_sent++;
  endtask

  // hold the sender until every expected result is back
  task automatic drain();
    sample_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_cal(input logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6, valid_word);
    drain();
    write_reg(REG_C1, c1);
    write_reg(REG_C2, c2);
    write_reg(REG_C3, c3);
    write_reg(REG_C4, c4);
    write_reg(REG_C5, c5);
    write_reg(REG_C6, c6);
    write_reg(REG_CALIB_VALID, valid_word);
    cfg_we <= 1'b0;
    cur_c5 = c5;
    cal_loads++;
  endtask

  // random pair, temperature mostly near the reference point
  task automatic send_random_pair();
    int pick, spread, level;
    logic [RAW_W-1:0] d1, d2;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      d2 = RAW_W'($urandom);
    end else begin
      spread = (pick < 45) ? 1024 : (pick < 75) ? 131072 : 2097152;
      level  = (int'(cur_c5) << 8) + int'($urandom_range(0, 2 * spread)) - spread;
      if (level < 0) level = 0;
      else if (level > RAW_MAX) level = RAW_MAX;
      d2 = level[RAW_W-1:0];
    end
    pick = $urandom_range(0, 99);
    d1 = (pick < 5) ? '0 : (pick < 10) ? '1 : RAW_W'($urandom);
    send_item(d1, d2);
  endtask

  initial begin
    logic [COEF_W-1:0] valid_word;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // calibration still invalid after reset
    send_item(24'h000000, 24'h000000);
    send_item(24'hFFFFFF, 24'hFFFFFF);
    send_item(24'd9085466, 24'd8569150);

    // typical calibration: warm, breakpoints, cool, cold, very cold
    load_cal(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6, 16'h0001);
    send_item(24'd9085466, 24'd8569150);
    send_item(24'd9085466, 24'd8566784);
    send_item(24'd9085466, 24'd8566783);
    send_item(24'd9085466, 24'd8270497);
    send_item(24'd9085466, 24'd7529764);
    send_item(24'd9085466, 24'd7529763);
    send_item(24'd9085466, 24'd6788984);
    send_item(24'h000000, 24'h000000);
    send_item(24'hFFFFFF, 24'hFFFFFF);
    send_item(24'hFFFFFF, 24'h000000);

    // a write to the unused index changes nothing
    drain();
    write_reg(REG_UNUSED, COEF_W'($urandom));
    cfg_we <= 1'b0;
    send_item(24'd9085466, 24'd8569150);

    // extreme calibration words
    load_cal('0, '0, '0, '0, '0, '0, 16'h0001);
    send_item(24'hFFFFFF, 24'hFFFFFF);
    send_item(24'h000000, 24'h000000);
    send_item(24'hFFFFFF, 24'h000000);
    load_cal('1, '1, '1, '1, '1, '1, 16'hFFFF);
    send_item(24'hFFFFFF, 24'hFFFFFF);
    send_item(24'h000000, 24'h000000);
    send_item(24'hFFFFFF, 24'h000000);
    send_item(24'h000000, 24'hFFFFFF);

    // only bit 0 of the valid word counts
    load_cal(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6, 16'hFFFE);
    send_item(24'd9085466, 24'd8569150);
    send_item(24'hFFFFFF, 24'h000000);

    // random phases, each with its own calibration load and an idling pattern by phase
    for (int phase = 0; phase < PHASES; phase++) begin
      valid_word = COEF_W'($urandom);
      valid_word[0] = (phase != 6);
      case (phase)
        0: load_cal(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6, valid_word);
        1: load_cal('0, '0, '0, '0, '0, '0, valid_word);
        2: load_cal('1, '1, '1, '1, '1, '1, valid_word);
        default: load_cal(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                          COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                          valid_word);
      endcase
      case (phase)
        3: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        4: begin
          // long result hold while items keep coming fills the pipe
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_requests++;
        end
        8: begin
          send_idle_pct = 10;
          recv_idle_pct = 60;
        end
        default: begin
          send_idle_pct = 30;
          recv_idle_pct = 30;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_pair();
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("run covered %0d items and %0d checked results under %0d calibration loads",
             items_sent, checked, cal_loads);
    $display("sample side held off for %0d cycles during result holds", input_blocked);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS baro_pressure_temp_compensation");
    else
      $display("FAIL baro_pressure_temp_compensation");
    $finish;
  end

endmodule

FILE: sim.f
src/bpc_pkg.sv
src/bpc_first_order.sv
src/bpc_second_order.sv
src/bpc_pressure.sv
src/baro_pressure_temp_compensation.sv
tb/compensation_checker.sv
tb/testbench.sv
